>>> hw/rtl/attg_pkg.sv
// ============================================================================
// attg_pkg
// Shared types, constants and the color palette of the text terminal grid.
// ============================================================================
package attg_pkg;

  localparam int MAX_COLS_DEF     = 256;
  localparam int MAX_ROWS_DEF     = 128;
  localparam int ESC_BUF_SIZE_DEF = 16;

  localparam logic [7:0] ESC_CODE    = 8'h1B;
  localparam logic [3:0] DEFAULT_IDX = 4'd7;
  localparam logic [6:0] SPACE_CHAR  = 7'h20;

  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_COLS    = 2'd1;
  localparam logic [1:0] REG_ROWS    = 2'd2;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_START = 2'd1,
    ESC_CSI   = 2'd2
  } esc_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP,
    ST_SWEEP,
    ST_INIT,
    ST_FIX
  } ctl_state_t;

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h555555;
      4'd1:    rgb = 24'hE06C75;
      4'd2:    rgb = 24'h98C379;
      4'd3:    rgb = 24'hE5C07B;
      4'd4:    rgb = 24'h61AFEF;
      4'd5:    rgb = 24'hC678DD;
      4'd6:    rgb = 24'h56B6C2;
      4'd7:    rgb = 24'hE0E0E0;
      4'd8:    rgb = 24'h808080;
      4'd9:    rgb = 24'hFF6E6E;
      4'd10:   rgb = 24'hB5E890;
      4'd11:   rgb = 24'hF0DA85;
      4'd12:   rgb = 24'h82C0FF;
      4'd13:   rgb = 24'hE0A0F0;
      4'd14:   rgb = 24'h80E0E8;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  // SGR value to color; keep the old color for values with no meaning.
  function automatic logic [3:0] sgr_color(input logic [7:0] v, input logic [3:0] cur);
    logic [3:0] c;
    c = cur;
    if (v == 8'd0 || v == 8'd39) c = DEFAULT_IDX;
    else if (v >= 8'd30 && v <= 8'd37) c = 4'(v - 8'd30);
    else if (v >= 8'd90 && v <= 8'd97) c = 4'(v - 8'd82);
    return c;
  endfunction

endpackage

>>> hw/rtl/ansi_text_terminal_grid_core.sv
// ============================================================================
// ansi_text_terminal_grid_core
// Byte-fed ANSI terminal keeping a character grid with color per cell.
// ============================================================================
// A feed byte's result is registered in the cycle after acceptance; a read goes
// through ST_READ and ST_RESP first. Scrolls and clears hold busy high while
// sweeping one row or the whole area through the one write port. After reset all
// MAX_ROWS*MAX_COLS cells are cleared, one per cycle, busy high. An idle size
// write leaving top_r >= the new row count holds busy high and cfg_ready low
// while top_r is reduced. Results show for one cycle; the receiver cannot stall.
module ansi_text_terminal_grid_core import attg_pkg::*; #(
  parameter int MAX_COLS     = MAX_COLS_DEF,
  parameter int MAX_ROWS     = MAX_ROWS_DEF,
  parameter int ESC_BUF_SIZE = ESC_BUF_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_byte_in,
  input  logic [6:0]  in_read_row,
  input  logic [7:0]  in_read_col,
  output logic        out_valid,
  output logic [6:0]  out_cell_char,
  output logic [23:0] out_cell_rgb,
  output logic [6:0]  out_cell_row,
  output logic [7:0]  out_cell_col,
  output logic        out_drew,
  output logic        out_scrolled,
  output logic        out_cleared,
  output logic [6:0]  out_cursor_row_out,
  output logic [7:0]  out_cursor_col_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int PW = $clog2(ESC_BUF_SIZE);

  ctl_state_t st_r, st_nxt;
  esc_state_t esc_r;
  logic        en_r;
  logic [8:0]  cols_reg_r;
  logic [7:0]  rows_reg_r;
  logic [RW-1:0] top_r, crow_r;
  logic [CW-1:0] ccol_r;
  logic [3:0]  cur_color_r, pend_r;
  logic [PW-1:0] pcnt_r;
  logic [7:0]  pval_r;
  logic        dpend_r, ptwo_r;

  // sweep machinery
  logic [RW-1:0] sw_row_r, sw_row_end_r;
  logic [CW-1:0] sw_col_r;
  logic [AW-1:0] init_r;

  // read request
  logic [6:0]  rd_row_r;
  logic [7:0]  rd_col_r;
  logic        rd_in_r;

  // effective sizes
  logic [10:0] cols_lim, rows_lim;
  assign cols_lim = (11'(cols_reg_r) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(cols_reg_r);
  assign rows_lim = (11'(rows_reg_r) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(rows_reg_r);

  assign cfg_ready = (st_r != ST_FIX);
  assign busy      = (st_r != ST_IDLE);

  // memory port signals
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [10:0]   wr_data, rd_data;

  attg_grid_mem #(.AW(AW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // physical row = (a + b) mod rows, a,b < rows
  function automatic logic [RW-1:0] addmod(input logic [RW-1:0] a, input logic [RW-1:0] b,
                                            input logic [10:0] n);
    logic [11:0] s;
    s = 12'(a) + 12'(b);
    if (s >= 12'(n)) s = s - 12'(n);
    return RW'(s);
  endfunction

  // ---------------- feed byte logic (combinational) ----------------
  logic        acc;
  logic        feed_ok;
  logic [7:0]  c;
  logic        is_digit, is_sep;
  esc_state_t  esc_n;
  logic [3:0]  cur_n, pend_n, sgr_v;
  logic [PW-1:0] pcnt_n;
  logic [7:0]  pval_n;
  logic        dpend_n, ptwo_n;
  logic [RW-1:0] crow_n, top_n;
  logic [CW-1:0] ccol_n;
  logic [11:0] crow_w;
  logic [11:0] ccol_w;
  logic        drew, scroll, clear;
  logic [11:0] mul10;
  logic [RW-1:0] prow;

  assign acc = start && !busy;
  assign c   = in_byte_in;
  assign is_digit = (c >= 8'h30 && c <= 8'h39);
  assign is_sep   = (c == 8'h3B || c == 8'h3F);
  assign feed_ok  = en_r && cols_lim != 11'd0 && rows_lim != 11'd0;
  assign prow     = addmod(top_r, crow_r, rows_lim);
  assign mul10    = 12'(pval_r) * 12'd10 + 12'(c - 8'h30);

  always_comb begin
    esc_n = esc_r; cur_n = cur_color_r; pend_n = pend_r; pcnt_n = pcnt_r;
    pval_n = pval_r; dpend_n = dpend_r; ptwo_n = ptwo_r;
    crow_w = 12'(crow_r); ccol_w = 12'(ccol_r); top_n = top_r;
    drew = 1'b0; scroll = 1'b0; clear = 1'b0; sgr_v = pend_r;
    if (feed_ok) begin
      if (esc_r == ESC_NONE && c == ESC_CODE) begin
        esc_n = ESC_START;
      end else if (esc_r == ESC_START) begin
        if (c == 8'h5B) begin
          esc_n = ESC_CSI; pcnt_n = '0; pval_n = '0; dpend_n = 1'b0;
          ptwo_n = 1'b0; pend_n = cur_color_r;
        end else begin
          esc_n = ESC_NONE;
        end
      end else if (esc_r == ESC_CSI) begin
        if (is_digit || is_sep) begin
          if (32'(pcnt_r) < ESC_BUF_SIZE - 1) begin
            ptwo_n = (pcnt_r == '0) && (c == 8'h32);
            pcnt_n = pcnt_r + 1'b1;
            if (is_digit) begin
              pval_n  = (mul10 > 12'd255) ? 8'd255 : mul10[7:0];
              dpend_n = 1'b1;
            end else begin
              pend_n  = sgr_color(pval_r, pend_r);
              pval_n  = '0;
              dpend_n = 1'b0;
            end
          end
        end else begin
          if (c == 8'h6D) begin
            if (pcnt_r == '0) sgr_v = DEFAULT_IDX;
            else if (dpend_r) sgr_v = sgr_color(pval_r, pend_r);
            cur_n = sgr_v;
          end else if (c == 8'h4A) begin
            clear = (pcnt_r == PW'(1)) && ptwo_r;
          end else if (c == 8'h48 && pcnt_r == '0) begin
            crow_w = '0; ccol_w = '0;
          end
          esc_n = ESC_NONE; pcnt_n = '0; pval_n = '0; dpend_n = 1'b0; ptwo_n = 1'b0;
        end
      end else begin
        if (c == 8'h0A) begin
          ccol_w = '0; crow_w = 12'(crow_r) + 12'd1;
        end else if (c == 8'h0D) begin
          ccol_w = '0;
        end else if (c >= 8'h20 && c < 8'h7F) begin
          drew = 1'b1;
          ccol_w = 12'(ccol_r) + 12'd1;
          if (ccol_w >= 12'(cols_lim)) begin
            ccol_w = '0; crow_w = 12'(crow_r) + 12'd1;
          end
        end
        if (crow_w >= 12'(rows_lim)) begin
          scroll = 1'b1;
          top_n  = addmod(top_r, RW'(1), rows_lim);
          crow_w = 12'(rows_lim) - 12'd1;
        end
      end
    end
    crow_n = RW'(crow_w);
    ccol_n = CW'(ccol_w);
  end

  // ---------------- config clamp ----------------
  logic [10:0] ncols, nrows;
  logic [RW-1:0] crow_cfg;
  logic [CW-1:0] ccol_cfg;
  logic cfg_wr;
  logic cfg_fix;
  assign cfg_wr = cfg_valid && cfg_ready;
  always_comb begin
    ncols = cols_lim; nrows = rows_lim;
    if (cfg_wr && cfg_index == REG_COLS)
      ncols = (11'(cfg_data) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(cfg_data);
    if (cfg_wr && cfg_index == REG_ROWS)
      nrows = (11'(cfg_data[7:0]) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(cfg_data[7:0]);
    crow_cfg = crow_r; ccol_cfg = ccol_r;
    // The top row is reduced afterwards in ST_FIX by repeated subtraction.
    cfg_fix = cfg_wr && (nrows != 11'd0) && (11'(top_r) >= nrows);
    if (nrows != 11'd0) begin
      if (11'(crow_r) >= nrows) crow_cfg = RW'(nrows - 11'd1);
    end
    if (ncols != 11'd0 && 11'(ccol_r) >= ncols) ccol_cfg = CW'(ncols - 11'd1);
  end

  // ---------------- control FSM ----------------
  logic sweep_last;
  assign sweep_last = (11'(sw_col_r) == cols_lim - 11'd1) && (sw_row_r == sw_row_end_r);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_INIT:  if (init_r == '1) st_nxt = ST_IDLE;
      ST_IDLE:  if (acc) begin
                  if (in_action) st_nxt = ST_READ;
                  else if (scroll || clear) st_nxt = ST_SWEEP;
                end else if (cfg_fix) begin
                  st_nxt = ST_FIX;
                end
      ST_READ:  st_nxt = ST_RESP;
      ST_RESP:  st_nxt = ST_IDLE;
      ST_SWEEP: if (sweep_last) st_nxt = ST_IDLE;
      ST_FIX:   if (11'(top_r) < rows_lim) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en = 1'b0; wr_addr = '0; wr_data = {DEFAULT_IDX, SPACE_CHAR};
    rd_addr = {addmod(top_r, RW'(rd_row_r), rows_lim), CW'(rd_col_r)};
    unique case (st_r)
      ST_INIT: begin
        wr_en = 1'b1; wr_addr = init_r;
      end
      ST_SWEEP: begin
        wr_en = 1'b1; wr_addr = {sw_row_r, sw_col_r};
      end
      ST_IDLE: begin
        wr_en   = acc && !in_action && drew;
        wr_addr = {prow, ccol_r};
        wr_data = {cur_color_r, c[6:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_INIT; init_r <= '0; esc_r <= ESC_NONE; en_r <= 1'b0;
      cols_reg_r <= 9'd80; rows_reg_r <= 8'd25; top_r <= '0; crow_r <= '0;
      ccol_r <= '0; cur_color_r <= DEFAULT_IDX; pend_r <= DEFAULT_IDX;
      pcnt_r <= '0; pval_r <= '0; dpend_r <= 1'b0; ptwo_r <= 1'b0;
      out_valid <= 1'b0; sw_row_r <= '0; sw_col_r <= '0; sw_row_end_r <= '0;
    end else begin
      st_r <= st_nxt;
      out_valid <= 1'b0;
      if (st_r == ST_INIT) init_r <= init_r + 1'b1;
      if (st_r == ST_FIX && 11'(top_r) >= rows_lim) top_r <= RW'(11'(top_r) - rows_lim);
      if (cfg_wr) begin
        if (cfg_index == REG_ENABLED) en_r <= cfg_data[0];
        if (cfg_index == REG_COLS) cols_reg_r <= cfg_data;
        if (cfg_index == REG_ROWS) rows_reg_r <= cfg_data[7:0];
        if (cfg_index == REG_COLS || cfg_index == REG_ROWS) begin
          crow_r <= crow_cfg; ccol_r <= ccol_cfg;
        end
      end
      if (st_r == ST_SWEEP) begin
        if (11'(sw_col_r) == cols_lim - 11'd1) begin
          sw_col_r <= '0; sw_row_r <= sw_row_r + 1'b1;
        end else begin
          sw_col_r <= sw_col_r + 1'b1;
        end
      end
      if (st_r == ST_RESP) out_valid <= 1'b1;
      if (st_r == ST_IDLE && acc && !in_action) begin
        esc_r <= esc_n; cur_color_r <= cur_n; pend_r <= pend_n; pcnt_r <= pcnt_n;
        pval_r <= pval_n; dpend_r <= dpend_n; ptwo_r <= ptwo_n;
        crow_r <= crow_n; ccol_r <= ccol_n; top_r <= top_n;
        out_valid <= 1'b1;
        sw_col_r <= '0;
        if (clear) begin
          sw_row_r <= '0; sw_row_end_r <= RW'(rows_lim - 11'd1);
        end else begin
          // new bottom row is the old top row
          sw_row_r <= top_r; sw_row_end_r <= top_r;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && acc) begin
      rd_row_r <= in_read_row; rd_col_r <= in_read_col;
      rd_in_r  <= (11'(in_read_row) < rows_lim) && (11'(in_read_col) < cols_lim);
      out_cell_char <= drew ? c[6:0] : 7'd0;
      out_cell_rgb  <= drew ? palette_rgb(cur_color_r) : 24'd0;
      out_cell_row  <= drew ? 7'(crow_r) : 7'd0;
      out_cell_col  <= drew ? 8'(ccol_r) : 8'd0;
      out_drew <= drew; out_scrolled <= scroll; out_cleared <= clear;
      out_cursor_row_out <= 7'(crow_n); out_cursor_col_out <= 8'(ccol_n);
    end
    if (st_r == ST_RESP) begin
      out_cell_char <= rd_in_r ? rd_data[6:0] : SPACE_CHAR;
      out_cell_rgb  <= palette_rgb(rd_in_r ? rd_data[10:7] : DEFAULT_IDX);
      out_cell_row  <= rd_row_r; out_cell_col <= rd_col_r;
      out_drew <= 1'b0; out_scrolled <= 1'b0; out_cleared <= 1'b0;
      out_cursor_row_out <= 7'(crow_r); out_cursor_col_out <= 8'(ccol_r);
    end
  end

endmodule

>>> hw/rtl/attg_grid_mem.sv
// ============================================================================
// attg_grid_mem
// Grid memory: one write port and one registered read port, char plus color.
// ============================================================================
module attg_grid_mem import attg_pkg::*; #(
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [10:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [10:0]   rd_data
);

  logic [10:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> tb/sv/ansi_text_terminal_grid_core_tb.sv
// ============================================================================
// ansi_text_terminal_grid_core_tb
// Self-checking bench for the byte-fed text terminal. A behavioral terminal
// model predicts untyped results. A short table of directed bytes and reads runs
// first. Random phases follow under several size settings: well-formed escape
// sequences, text, line control, reads and noise, with random sender gaps.
// ============================================================================
`timescale 1ns / 1ps

module ansi_text_terminal_grid_core_tb;
  import attg_pkg::*;

  localparam int  GRID_COLS   = 256;
  localparam int  GRID_ROWS   = 128;
  localparam int  PARAM_LIMIT = 16;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam bit  ACT_FEED    = 1'b0;
  localparam bit  ACT_READ    = 1'b1;

  typedef struct {
    logic [6:0]  ch;
    logic [23:0] rgb;
    logic [6:0]  row;
    logic [7:0]  col;
    logic        drew;
    logic        scrolled;
    logic        cleared;
    logic [6:0]  crow;
    logic [7:0]  ccol;
  } cell_result_t;

  typedef struct {
    bit           act;
    logic [7:0]   data;
    logic [6:0]   rrow;
    logic [7:0]   rcol;
    bit           typed;
    cell_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [7:0]  in_byte_in;
  logic [6:0]  in_read_row;
  logic [7:0]  in_read_col;
  logic        out_valid;
  logic [6:0]  out_cell_char;
  logic [23:0] out_cell_rgb;
  logic [6:0]  out_cell_row;
  logic [7:0]  out_cell_col;
  logic        out_drew;
  logic        out_scrolled;
  logic        out_cleared;
  logic [6:0]  out_cursor_row_out;
  logic [7:0]  out_cursor_col_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  ansi_text_terminal_grid_core DUT (.*);

  // Terminal model state.
  logic [6:0]  scr_char [GRID_ROWS*GRID_COLS];
  logic [3:0]  scr_color [GRID_ROWS*GRID_COLS];
  int unsigned term_en, term_cols, term_rows;
  int unsigned top_row, cur_row, cur_col, cur_color, pend_color;
  int unsigned param_cnt, param_val;
  esc_state_t  esc_st;
  bit          digits_pend, only_two;

  cell_result_t expected_cells[$];
  int          fail_count;
  int unsigned cycle_count;

  function automatic logic [23:0] color_rgb(input int unsigned idx);
    logic [23:0] pal [16] = '{24'h555555, 24'hE06C75, 24'h98C379, 24'hE5C07B,
                              24'h61AFEF, 24'hC678DD, 24'h56B6C2, 24'hE0E0E0,
                              24'h808080, 24'hFF6E6E, 24'hB5E890, 24'hF0DA85,
                              24'h82C0FF, 24'hE0A0F0, 24'h80E0E8, 24'hFFFFFF};
    return pal[idx & 15];
  endfunction

  function automatic int unsigned used_cols();
    return (term_cols > GRID_COLS) ? GRID_COLS : term_cols;
  endfunction

  function automatic int unsigned used_rows();
    return (term_rows > GRID_ROWS) ? GRID_ROWS : term_rows;
  endfunction

  function automatic void blank_line(input int unsigned prow, input int unsigned n);
    for (int c = 0; c < n; c++) begin
      scr_char[prow*GRID_COLS + c]  = SPACE_CHAR;
      scr_color[prow*GRID_COLS + c] = DEFAULT_IDX;
    end
  endfunction

  function automatic void take_sgr(input int unsigned v);
    if (v == 0 || v == 39) pend_color = DEFAULT_IDX;
    else if (v >= 30 && v <= 37) pend_color = v - 30;
    else if (v >= 90 && v <= 97) pend_color = v - 82;
  endfunction

  function automatic void clamp_cursor();
    int unsigned nc, nr;
    nc = used_cols();
    nr = used_rows();
    if (nr != 0) begin
      top_row = top_row % nr;
      if (cur_row >= nr) cur_row = nr - 1;
    end
    if (nc != 0 && cur_col >= nc) cur_col = nc - 1;
  endfunction

  function automatic void end_sequence();
    esc_st = ESC_NONE;
    param_cnt = 0;
    param_val = 0;
    digits_pend = 0;
    only_two = 0;
  endfunction

  // Feeds one byte into the model terminal and fills in the flags and cell.
  function automatic void feed_byte(input int unsigned b, inout cell_result_t r);
    int unsigned nc, nr, k;
    bit is_param;
    nc = used_cols();
    nr = used_rows();
    if (term_en == 0 || nc == 0 || nr == 0) return;
    if (esc_st == ESC_NONE && b == ESC_CODE) begin
      esc_st = ESC_START;
      return;
    end
    if (esc_st == ESC_START) begin
      if (b == "[") begin
        end_sequence();
        esc_st = ESC_CSI;
        pend_color = cur_color;
      end else begin
        esc_st = ESC_NONE;
      end
      return;
    end
    if (esc_st == ESC_CSI) begin
      is_param = (b >= "0" && b <= "9") || b == ";" || b == "?";
      if (is_param) begin
        if (param_cnt < PARAM_LIMIT - 1) begin
          only_two = (param_cnt == 0 && b == "2");
          param_cnt++;
          if (b >= "0" && b <= "9") begin
            param_val = param_val * 10 + (b - "0");
            if (param_val > 255) param_val = 255;
            digits_pend = 1;
          end else begin
            take_sgr(param_val);
            param_val = 0;
            digits_pend = 0;
          end
        end
        return;
      end
      if (b == "m") begin
        if (param_cnt == 0) pend_color = DEFAULT_IDX;
        else if (digits_pend) take_sgr(param_val);
        cur_color = pend_color & 15;
      end else if (b == "J") begin
        if (param_cnt == 1 && only_two) begin
          for (int rr = 0; rr < nr; rr++) blank_line(rr, nc);
          r.cleared = 1;
        end
      end else if (b == "H" && param_cnt == 0) begin
        cur_row = 0;
        cur_col = 0;
      end
      end_sequence();
      return;
    end
    if (b == 8'h0A) begin
      cur_col = 0;
      cur_row++;
    end else if (b == 8'h0D) begin
      cur_col = 0;
    end else if (b >= 8'h20 && b < 8'h7F) begin
      k = ((top_row + cur_row) % nr) * GRID_COLS + cur_col;
      scr_char[k]  = b[6:0];
      scr_color[k] = cur_color[3:0];
      r.ch   = b[6:0];
      r.rgb  = color_rgb(cur_color);
      r.row  = cur_row[6:0];
      r.col  = cur_col[7:0];
      r.drew = 1;
      cur_col++;
      if (cur_col >= nc) begin
        cur_col = 0;
        cur_row++;
      end
    end
    if (cur_row >= nr) begin
      top_row = (top_row + 1) % nr;
      blank_line((top_row + nr - 1) % nr, nc);
      cur_row = nr - 1;
      r.scrolled = 1;
    end
  endfunction

  function automatic cell_result_t terminal_step(input bit act, input int unsigned b,
                                                 input int unsigned rr,
                                                 input int unsigned rc);
    cell_result_t r;
    int unsigned nc, nr, k;
    r = '{default: '0};
    if (act == ACT_FEED) begin
      feed_byte(b, r);
    end else begin
      nc = used_cols();
      nr = used_rows();
      r.ch  = SPACE_CHAR;
      r.rgb = color_rgb(DEFAULT_IDX);
      r.row = rr[6:0];
      r.col = rc[7:0];
      if (rr < nr && rc < nc) begin
        k = ((top_row + rr) % nr) * GRID_COLS + rc;
        r.ch  = scr_char[k];
        r.rgb = color_rgb(scr_color[k]);
      end
    end
    r.crow = cur_row[6:0];
    r.ccol = cur_col[7:0];
    return r;
  endfunction

  function automatic void model_reset();
    foreach (scr_char[i]) begin
      scr_char[i]  = SPACE_CHAR;
      scr_color[i] = DEFAULT_IDX;
    end
    term_en = 0;
    term_cols = 80;
    term_rows = 25;
    top_row = 0;
    cur_row = 0;
    cur_col = 0;
    cur_color = DEFAULT_IDX;
    pend_color = DEFAULT_IDX;
    end_sequence();
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic check_field(input string nm, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
      fail_count++;
    end
  endtask

  // Result checker: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    cell_result_t e;
    if (rst_n && out_valid) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: result with no expectation, actual char %0h", $time, out_cell_char);
        fail_count++;
      end else begin
        e = expected_cells.pop_front();
        check_field("cell_char", e.ch, out_cell_char);
        check_field("cell_rgb", e.rgb, out_cell_rgb);
        check_field("cell_row", e.row, out_cell_row);
        check_field("cell_col", e.col, out_cell_col);
        check_field("drew", e.drew, out_drew);
        check_field("scrolled", e.scrolled, out_scrolled);
        check_field("cleared", e.cleared, out_cleared);
        check_field("cursor_row", e.crow, out_cursor_row_out);
        check_field("cursor_col", e.ccol, out_cursor_col_out);
      end
    end
  end

  int sender_idle_pct;

  // Called just after a falling edge; returns just after a falling edge once the item is taken.
  task automatic send_item(input bit act, input logic [7:0] b, input logic [6:0] rr,
                           input logic [7:0] rc, input bit typed = 0,
                           input cell_result_t typed_res = '{default: '0});
    cell_result_t p;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start       = 1'b1;
    in_action   = act;
    in_byte_in  = b;
    in_read_row = rr;
    in_read_col = rc;
    do @(posedge clk); while (busy);
    p = terminal_step(act, b, rr, rc);
    expected_cells.push_back(typed ? typed_res : p);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_FEED, s[i], 0, 0);
  endtask

  // Waits for every result and for any sweep still running, then writes a register.
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    while (expected_cells.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ENABLED) term_en = val[0];
    else if (idx == REG_COLS) begin
      term_cols = val;
      clamp_cursor();
    end else begin
      term_rows = val[7:0];
      clamp_cursor();
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(input bit en, input logic [8:0] cols, input logic [8:0] rows);
    write_reg(REG_ENABLED, {8'd0, en});
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
  endtask

  function automatic int unsigned pick_sgr();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 39;
      2, 3:    return $urandom_range(30, 37);
      4:       return $urandom_range(90, 97);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  task automatic run_random(input int n);
    int sent, kind, len;
    string s;
    string finals, jh;
    int unsigned area;
    sent = 0;
    finals = "ABCDJKHfm";
    jh = "JH";
    while (sent < n) begin
      area = used_rows() * used_cols();
      kind = $urandom_range(0, 99);
      s = "";
      if (kind < 30) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) s = {s, string'(8'($urandom_range(32, 126)))};
      end else if (kind < 38) begin
        s = ($urandom_range(0, 2) == 0) ? "\r" : "\n";
      end else if (kind < 55) begin
        s = {8'h1B, "["};
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
          if (i != 0) s = {s, ($urandom_range(0, 3) == 0) ? string'("?") : string'(";")};
          s = {s, $sformatf("%0d", pick_sgr())};
        end
        if ($urandom_range(0, 7) == 0) s = {s, ";"};
        s = {s, "m"};
      end else if (kind < 60) begin
        if (area <= 4096 || $urandom_range(0, 15) == 0) s = {8'h1B, "[2J"};
      end else if (kind < 64) begin
        s = {8'h1B, "[H"};
      end else if (kind < 70) begin
        case ($urandom_range(0, 3))
          0: begin
            // Long parameter strings overflow the parameter buffer.
            s = {8'h1B, "["};
            len = $urandom_range(0, 20);
            for (int i = 0; i < len; i++) s = {s, string'(8'($urandom_range(48, 59)))};
            s = {s, string'(finals[$urandom_range(0, 8)])};
          end
          1: s = {8'h1B, string'(8'($urandom_range(32, 126)))};
          2: s = {8'h1B, "[", 8'h1B, "x"};
          default: s = {string'(8'h1B), "[", $sformatf("%0d", $urandom_range(0, 30)),
                        string'(jh[$urandom_range(0, 1)])};
        endcase
      end else if (kind < 80) begin
        if ($urandom_range(0, 3) != 0 && area != 0)
          send_item(ACT_READ, 8'($urandom), 7'($urandom_range(0, used_rows() - 1)),
                    8'($urandom_range(0, used_cols() - 1)));
        else
          send_item(ACT_READ, 8'($urandom), 7'($urandom), 8'($urandom));
        sent++;
      end else begin
        send_item(ACT_FEED, 8'($urandom_range(0, 255)), 7'($urandom), 8'($urandom));
        sent++;
      end
      feed_text(s);
      sent += s.len();
    end
  endtask

  stim_row_t dir_tbl [23];

  initial begin
    cell_result_t none;
    int waited;
    none = '{default: '0};
    fail_count = 0;
    model_reset();
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_FEED;
    in_byte_in = '0;
    in_read_row = '0;
    in_read_col = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ENABLED;
    cfg_data = '0;
    sender_idle_pct = 0;

    dir_tbl[0]  = '{ACT_READ, 8'h00, 7'd0, 8'd0, 1,
                    '{7'h20, 24'hE0E0E0, 7'd0, 8'd0, 0, 0, 0, 7'd0, 8'd0}};
    dir_tbl[1]  = '{ACT_FEED, 8'h41, 7'd0, 8'd0, 1,
                    '{7'h41, 24'hE0E0E0, 7'd0, 8'd0, 1, 0, 0, 7'd0, 8'd1}};
    dir_tbl[2]  = '{ACT_FEED, 8'h1B, 7'd0, 8'd0, 1,
                    '{7'h00, 24'h000000, 7'd0, 8'd0, 0, 0, 0, 7'd0, 8'd1}};
    dir_tbl[3]  = '{ACT_FEED, "[",   7'd0, 8'd0, 0, none};
    dir_tbl[4]  = '{ACT_FEED, "9",   7'd0, 8'd0, 0, none};
    dir_tbl[5]  = '{ACT_FEED, "7",   7'd0, 8'd0, 0, none};
    dir_tbl[6]  = '{ACT_FEED, "m",   7'd0, 8'd0, 0, none};
    dir_tbl[7]  = '{ACT_FEED, 8'h7E, 7'd0, 8'd0, 1,
                    '{7'h7E, 24'hFFFFFF, 7'd0, 8'd1, 1, 0, 0, 7'd0, 8'd2}};
    dir_tbl[8]  = '{ACT_FEED, 8'h7F, 7'd0, 8'd0, 1,
                    '{7'h00, 24'h000000, 7'd0, 8'd0, 0, 0, 0, 7'd0, 8'd2}};
    dir_tbl[9]  = '{ACT_FEED, 8'hFF, 7'd0, 8'd0, 0, none};
    dir_tbl[10] = '{ACT_FEED, 8'h0A, 7'd0, 8'd0, 0, none};
    dir_tbl[11] = '{ACT_FEED, 8'h0D, 7'd0, 8'd0, 0, none};
    dir_tbl[12] = '{ACT_FEED, 8'h1B, 7'd0, 8'd0, 0, none};
    dir_tbl[13] = '{ACT_FEED, "[",   7'd0, 8'd0, 0, none};
    dir_tbl[14] = '{ACT_FEED, "3",   7'd0, 8'd0, 0, none};
    dir_tbl[15] = '{ACT_FEED, "?",   7'd0, 8'd0, 0, none};
    dir_tbl[16] = '{ACT_FEED, "m",   7'd0, 8'd0, 0, none};
    dir_tbl[17] = '{ACT_FEED, 8'h20, 7'd0, 8'd0, 0, none};
    dir_tbl[18] = '{ACT_READ, 8'h00, 7'd127, 8'd255, 1,
                    '{7'h20, 24'hE0E0E0, 7'd127, 8'd255, 0, 0, 0, 7'd1, 8'd1}};
    dir_tbl[19] = '{ACT_FEED, 8'h1B, 7'd0, 8'd0, 0, none};
    dir_tbl[20] = '{ACT_FEED, "[",   7'd0, 8'd0, 0, none};
    dir_tbl[21] = '{ACT_FEED, "2",   7'd0, 8'd0, 0, none};
    dir_tbl[22] = '{ACT_FEED, "J",   7'd0, 8'd0, 0, none};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    setup(1'b1, 9'd80, 9'd25);
    foreach (dir_tbl[i])
      send_item(dir_tbl[i].act, dir_tbl[i].data, dir_tbl[i].rrow, dir_tbl[i].rcol,
                dir_tbl[i].typed, dir_tbl[i].res);
    // Home, ESC inside a sequence, and a wrap with scroll on a tiny screen.
    feed_text({8'h1B, "[H", 8'h1B, "[", 8'h1B, "xy"});
    setup(1'b1, 9'd2, 9'd1);
    feed_text("abc");

    for (int ph = 0; ph < 12; ph++) begin
      sender_idle_pct = (ph % 3 == 0) ? 24 : (ph % 3 == 1) ? 54 : 0;
      case (ph)
        0:  setup(1'b1, 9'd8, 9'd4);
        1:  setup(1'b1, 9'd1, 9'd1);
        2:  setup(1'b1, 9'd256, 9'd128);
        3:  setup(1'b1, 9'd511, 9'd255);
        4:  setup(1'b1, 9'd20, 9'd6);
        5:  setup(1'b0, 9'd20, 9'd6);
        6:  setup(1'b1, 9'd0, 9'd5);
        7:  setup(1'b1, 9'd5, 9'd0);
        8:  setup(1'b1, 9'd40, 9'd10);
        9:  setup(1'b1, 9'd3, 9'd128);
        10: setup(1'b1, 9'd256, 9'd2);
        default: setup(1'b1, 9'd12, 9'd5);
      endcase
      run_random((ph == 2 || ph == 3 || ph == 5 || ph == 6 || ph == 7) ? 40 : 80);
    end

    waited = 0;
    while ((expected_cells.size() != 0 || busy) && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (fail_count == 0 && expected_cells.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
